### src/swcd_pkg.sv
// ----------------------------------------------------------------------------
// swcd_pkg
// Shared types and constants for the speed window crash detector.
// ----------------------------------------------------------------------------
package swcd_pkg;

   localparam int LONG_W     = 13;
   localparam int LAT_W      = 10;
   localparam int MAG_W      = 14;
   localparam int LIM_W      = 8;
   localparam int RAD_W      = 2 * MAG_W;
   localparam int REM_W      = MAG_W + 1;
   localparam int ROOT_STEPS = MAG_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   localparam int HISTORY_DEPTH_DEF = 5;

   localparam logic [LIM_W-1:0] LOW_LIMIT_RST  = LIM_W'(7);
   localparam logic [LIM_W-1:0] HIGH_LIMIT_RST = LIM_W'(10);

   typedef enum logic {
      CSR_LOW_LIMIT  = 1'b0,
      CSR_HIGH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic root_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

### src/speed_window_crash_detect.sv
// ----------------------------------------------------------------------------
// speed_window_crash_detect
// Speed magnitude by integer square root, sliding history, sticky crash flag.
// ----------------------------------------------------------------------------
// sequence: accept, square, root (one bit per cycle, 14 root bits), commit
//   to rsp_valid, plus any wait for the previous rsp word to leave
// no new req word is accepted until the last one commits (req_ready in idle)
// reset: synchronous; history and crash flag cleared, limits back to 7 and 10
// ----------------------------------------------------------------------------
module speed_window_crash_detect #(
   parameter int HISTORY_DEPTH = swcd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [swcd_pkg::LONG_W-1:0]           req_speed_long,
   input  logic signed [swcd_pkg::LAT_W-1:0]     req_speed_lat,
   input  logic                                  req_clear_alarm,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [swcd_pkg::MAG_W-1:0]            rsp_speed_mag,
   output logic                                  rsp_crash_flag,
   input  logic                                  csr_wr_en,
   input  swcd_pkg::csr_index_type               csr_index,
   input  logic [swcd_pkg::LIM_W-1:0]            csr_wdata
);

   swcd_pkg::cmd_type    cmd;
   swcd_pkg::status_type status;

   swcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swcd_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_speed_long  (req_speed_long),
      .req_speed_lat   (req_speed_lat),
      .req_clear_alarm (req_clear_alarm),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed_mag   (rsp_speed_mag),
      .rsp_crash_flag  (rsp_crash_flag)
   );

endmodule

### src/swcd_ctrl.sv
// ----------------------------------------------------------------------------
// swcd_ctrl
// Sequencer: accept, square, one root bit per cycle, commit to output.
// ----------------------------------------------------------------------------
module swcd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swcd_pkg::status_type  status,
   output swcd_pkg::cmd_type     cmd
);

   swcd_pkg::state_type              state_ff, state_in;
   logic [swcd_pkg::STEP_W-1:0]      step_cnt_ff, step_cnt_in;
   logic                             last_step;

   assign last_step = (step_cnt_ff == swcd_pkg::STEP_W'(swcd_pkg::ROOT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swcd_pkg::ST_IDLE: begin
            if (req_valid) state_in = swcd_pkg::ST_SQUARE;
         end
         swcd_pkg::ST_SQUARE: begin
            state_in = swcd_pkg::ST_ROOT;
         end
         swcd_pkg::ST_ROOT: begin
            if (last_step) state_in = swcd_pkg::ST_COMMIT;
         end
         swcd_pkg::ST_COMMIT: begin
            if (status.out_free) state_in = swcd_pkg::ST_IDLE;
         end
         default: begin
            state_in = swcd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      step_cnt_in = step_cnt_ff;
      case (state_ff)
         swcd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load    = req_valid;
         end
         swcd_pkg::ST_SQUARE: begin
            cmd.square  = 1'b1;
            step_cnt_in = '0;
         end
         swcd_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_cnt_in   = step_cnt_ff + 1'b1;
         end
         swcd_pkg::ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= swcd_pkg::ST_IDLE;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

endmodule

### src/swcd_dp.sv
// ----------------------------------------------------------------------------
// swcd_dp
// Datapath: squares, bit-serial square root, speed history, crash latch,
// limit registers and the result register.
// ----------------------------------------------------------------------------
module swcd_dp #(
   parameter int HISTORY_DEPTH = swcd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swcd_pkg::cmd_type                      cmd,
   output swcd_pkg::status_type                   status,
   input  logic [swcd_pkg::LONG_W-1:0]            req_speed_long,
   input  logic signed [swcd_pkg::LAT_W-1:0]      req_speed_lat,
   input  logic                                   req_clear_alarm,
   input  logic                                   csr_wr_en,
   input  swcd_pkg::csr_index_type                csr_index,
   input  logic [swcd_pkg::LIM_W-1:0]             csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [swcd_pkg::MAG_W-1:0]             rsp_speed_mag,
   output logic                                   rsp_crash_flag
);

   localparam int MW = swcd_pkg::MAG_W;
   localparam int RW = swcd_pkg::RAD_W;
   localparam int EW = swcd_pkg::REM_W;
   localparam int LW = swcd_pkg::LIM_W;
   localparam int XW = swcd_pkg::LONG_W;
   localparam int YW = swcd_pkg::LAT_W;

   // operand capture
   logic [XW-1:0]   long_ff;
   logic [YW-1:0]   lat_abs_ff, lat_abs_in;
   logic            clr_ff;

   // limits
   logic [LW-1:0]   low_lim_ff, high_lim_ff;

   // square root
   logic [RW-1:0]   rad_ff, rad_in;
   logic [MW-1:0]   root_ff, root_in;
   logic [EW-1:0]   rem_ff, rem_in;
   logic [2*XW-1:0] long_sq;
   logic [2*YW-1:0] lat_sq;
   logic [EW+1:0]   rem_sh, trial, rem_diff;

   // history and result
   logic [MW-1:0]   hist_ff [HISTORY_DEPTH];
   logic            crash_ff, crash_in, hit;
   logic [MW:0]     bound_low, bound_high;
   logic            rsp_valid_ff;
   logic [MW-1:0]   out_mag_ff;
   logic            out_flag_ff;

   assign lat_abs_in = req_speed_lat[YW-1] ? (~req_speed_lat + 1'b1) : req_speed_lat;

   assign long_sq = (2*XW)'(long_ff) * (2*XW)'(long_ff);
   assign lat_sq  = (2*YW)'(lat_abs_ff) * (2*YW)'(lat_abs_ff);

   assign rem_sh   = {rem_ff, rad_ff[RW-1 -: 2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign rem_diff = rem_sh - trial;

   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (cmd.square) begin
         rad_in  = RW'(long_sq) + RW'(lat_sq);
         root_in = '0;
         rem_in  = '0;
      end else if (cmd.root_step) begin
         rad_in = {rad_ff[RW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_diff[EW-1:0];
            root_in = {root_ff[MW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[EW-1:0];
            root_in = {root_ff[MW-2:0], 1'b0};
         end
      end
   end

   // window compare against the entry that becomes oldest after the shift
   assign bound_low  = {1'b0, hist_ff[1]} + (MW+1)'({low_lim_ff, 2'b00});
   assign bound_high = {1'b0, hist_ff[1]} + (MW+1)'({high_lim_ff, 2'b00});
   assign hit        = ({1'b0, root_ff} > bound_low) && ({1'b0, root_ff} < bound_high);
   assign crash_in   = clr_ff ? 1'b0 : (crash_ff | hit);

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         long_ff    <= req_speed_long;
         lat_abs_ff <= lat_abs_in;
         clr_ff     <= req_clear_alarm;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      if (cmd.commit) begin
         out_mag_ff  <= root_ff;
         out_flag_ff <= crash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_lim_ff   <= swcd_pkg::LOW_LIMIT_RST;
         high_lim_ff  <= swcd_pkg::HIGH_LIMIT_RST;
         crash_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               swcd_pkg::CSR_LOW_LIMIT:  low_lim_ff  <= csr_wdata;
               swcd_pkg::CSR_HIGH_LIMIT: high_lim_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            crash_ff     <= crash_in;
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
               hist_ff[i] <= hist_ff[i+1];
            end
            hist_ff[HISTORY_DEPTH-1] <= root_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed_mag  = out_mag_ff;
   assign rsp_crash_flag = out_flag_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.square, cmd.root_step, cmd.commit}))
      else $error("more than one datapath command");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result word still pending");

   a_clear_wins: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && clr_ff |=> !rsp_crash_flag && !crash_ff)
      else $error("clear did not drop crash flag");

   a_hist_newest: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> hist_ff[HISTORY_DEPTH-1] == rsp_speed_mag)
      else $error("history newest entry differs from result");

endmodule
